[design/tlbdp_pkg.sv]
// Shared types and constants for the TLB demand-paging translator.
package tlbdp_pkg;

    localparam logic CMD_LOAD      = 1'b0;
    localparam logic CMD_TRANSLATE = 1'b1;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_cap;     // capture the input item
        logic store_wr;     // write backing store byte
        logic tlb_step;     // examine the next TLB entry
        logic pt_step;      // examine the next page-table entry
        logic pt_read;      // issue a page-table read
        logic copy_start;   // clear copy counters, start a fault
        logic copy_rd;      // read one backing byte
        logic copy_wr;      // write one physical byte
        logic fault_commit; // record page in table and TLB
        logic phys_rd;      // read result byte
        logic result;       // present result
    } t_ctrl;

    // Datapath to controller status.
    typedef struct packed {
        logic is_translate;
        logic tlb_match;
        logic tlb_last;
        logic pt_match;
        logic pt_last;
        logic copy_last;
    } t_stat;

endpackage

[design/tlbdp_datapath.sv]
// Datapath: TLB, page table, memories and counters.
module tlbdp_datapath
    import tlbdp_pkg::*;
#(
    parameter int TLB_ENTRIES = 16,
    parameter int PAGE_COUNT  = 256,
    parameter int OFFSET_BITS = 8,
    parameter int STORE_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl       i_ctrl,
    output t_stat       o_stat,
    input  logic        i_command,
    input  logic [15:0] i_address,
    input  logic signed [7:0] i_data_byte,
    output logic        o_valid,
    output logic [15:0] o_physical_address,
    output logic signed [7:0] o_value,
    output logic        o_tlb_hit,
    output logic        o_page_fault
);
    localparam int TB = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int FB = $clog2(PAGE_COUNT);
    localparam int VPB = 16 - OFFSET_BITS;
    localparam int SB = $clog2(STORE_BYTES);
    localparam int PB = FB + OFFSET_BITS;
    localparam int PAGE_BYTES = 1 << OFFSET_BITS;
    localparam int PW = (PB > 16) ? PB : 16;

    logic [7:0]              r_store [STORE_BYTES];
    logic [7:0]              r_phys [PAGE_COUNT*PAGE_BYTES];
    logic [VPB-1:0]          r_fpage [PAGE_COUNT];
    logic [PAGE_COUNT-1:0]   r_fvalid;
    logic [VPB-1:0]          r_tpage [TLB_ENTRIES];
    logic [FB-1:0]           r_tframe [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0]  r_tvalid;

    logic                    r_cmd;
    logic [15:0]             r_addr;
    logic [7:0]              r_data;
    logic [TB-1:0]           r_ti;
    logic [FB-1:0]           r_pi;
    logic [FB-1:0]           r_frame;
    logic                    r_hit, r_fault;
    logic [FB-1:0]           r_used;
    logic [TB-1:0]           r_slot;
    logic [OFFSET_BITS-1:0]  r_rd_ofs, r_wr_ofs;
    logic                    r_rd_done;
    logic [7:0]              r_sbyte;
    logic [VPB-1:0]          r_pt_q;
    logic                    r_pt_qv;
    logic [7:0]              r_pbyte;
    logic                    r_valid;

    logic [VPB-1:0]          vpage;
    logic [OFFSET_BITS-1:0]  ofs;
    logic [PW-1:0]           paddr;
    logic [SB-1:0]           saddr;

    assign vpage = r_addr[15:OFFSET_BITS];
    assign ofs   = r_addr[OFFSET_BITS-1:0];
    assign paddr = PW'({r_frame, ofs});
    assign saddr = SB'({vpage, r_rd_ofs});

    assign o_stat.is_translate = r_cmd == CMD_TRANSLATE;
    assign o_stat.tlb_match = r_tvalid[r_ti] && r_tpage[r_ti] == vpage;
    assign o_stat.tlb_last  = r_ti == TB'(TLB_ENTRIES - 1);
    assign o_stat.pt_match  = r_pt_qv && r_pt_q == vpage;
    assign o_stat.pt_last   = r_pi == FB'(PAGE_COUNT - 1);
    assign o_stat.copy_last = r_wr_ofs == OFFSET_BITS'(PAGE_BYTES - 1);

    // Memories.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.store_wr)
            r_store[SB'(r_addr)] <= r_data;
        r_sbyte <= r_store[saddr];
        if (i_ctrl.copy_wr)
            r_phys[{r_used, r_wr_ofs}] <= r_sbyte;
        if (i_ctrl.phys_rd)
            r_pbyte <= r_phys[paddr[PB-1:0]];
        r_pt_q  <= r_fpage[r_pi];
        if (i_ctrl.fault_commit)
            r_fpage[r_used] <= vpage;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvalid <= '0;
            r_tvalid <= '0;
            r_used   <= '0;
            r_slot   <= '0;
            r_valid  <= 1'b0;
            r_ti     <= '0;
            r_pi     <= '0;
            r_pt_qv  <= 1'b0;
        end else begin
            r_valid <= i_ctrl.result;
            if (i_ctrl.load_cap) begin
                r_cmd   <= i_command;
                r_addr  <= i_address;
                r_data  <= i_data_byte;
                r_ti    <= '0;
                r_pi    <= '0;
                r_hit   <= 1'b0;
                r_fault <= 1'b0;
            end
            if (i_ctrl.tlb_step) begin
                if (o_stat.tlb_match) begin
                    r_frame <= r_tframe[r_ti];
                    r_hit   <= 1'b1;
                end
                r_ti <= r_ti + 1'b1;
            end
            r_pt_qv <= i_ctrl.pt_read && r_fvalid[r_pi];
            if (i_ctrl.pt_step) begin
                if (o_stat.pt_match)
                    r_frame <= r_pi;
                r_pi <= r_pi + 1'b1;
            end
            if (i_ctrl.copy_start) begin
                r_rd_ofs  <= '0;
                r_wr_ofs  <= '0;
                r_rd_done <= 1'b0;
                r_fault   <= 1'b1;
                r_frame   <= r_used;
                // the reused frame leaves the TLB
                for (int i = 0; i < TLB_ENTRIES; i++)
                    if (r_tframe[i] == r_used)
                        r_tvalid[i] <= 1'b0;
            end
            if (i_ctrl.copy_rd && !r_rd_done) begin
                r_rd_ofs <= r_rd_ofs + 1'b1;
                if (r_rd_ofs == OFFSET_BITS'(PAGE_BYTES - 1))
                    r_rd_done <= 1'b1;
            end
            if (i_ctrl.copy_wr)
                r_wr_ofs <= r_wr_ofs + 1'b1;
            if (i_ctrl.fault_commit) begin
                r_fvalid[r_used] <= 1'b1;
                r_tpage[r_slot]  <= vpage;
                r_tframe[r_slot] <= r_used;
                r_tvalid[r_slot] <= 1'b1;
                r_used <= (r_used == FB'(PAGE_COUNT - 1)) ? '0 : r_used + 1'b1;
                // slot follows frames_used mod TLB_ENTRIES
                r_slot <= (r_used == FB'(PAGE_COUNT - 1) ||
                           r_slot == TB'(TLB_ENTRIES - 1)) ? '0 : r_slot + 1'b1;
            end
        end
    end

    assign o_valid            = r_valid;
    assign o_physical_address = paddr[15:0];
    assign o_value            = r_pbyte;
    assign o_tlb_hit          = r_hit;
    assign o_page_fault       = r_fault;
endmodule

[design/tlbdp_ctrl.sv]
// Controller state machine for the translator.
module tlbdp_ctrl
    import tlbdp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    output logic  o_busy,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);
    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_TLB, S_PT_RD, S_PT_CHK, S_FAULT,
        S_COPY, S_COMMIT, S_READ, S_WAIT, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;

    always_comb begin
        o_ctrl  = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_start) begin
                o_ctrl.load_cap = 1'b1;
                n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (i_stat.is_translate) begin
                    n_state = S_TLB;
                end else begin
                    o_ctrl.store_wr = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_TLB: begin
                o_ctrl.tlb_step = 1'b1;
                if (i_stat.tlb_match)     n_state = S_READ;
                else if (i_stat.tlb_last) n_state = S_PT_RD;
            end
            S_PT_RD: begin
                o_ctrl.pt_read = 1'b1;
                n_state = S_PT_CHK;
            end
            S_PT_CHK: begin
                if (i_stat.pt_match) begin
                    o_ctrl.pt_step = 1'b1;
                    n_state = S_READ;
                end else if (i_stat.pt_last) begin
                    n_state = S_FAULT;
                end else begin
                    o_ctrl.pt_step = 1'b1;
                    n_state = S_PT_RD;
                end
            end
            S_FAULT: begin
                o_ctrl.copy_start = 1'b1;
                n_state = S_COPY;
            end
            S_COPY: begin
                // backing read is registered; the physical write follows in the next cycle
                o_ctrl.copy_rd = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                o_ctrl.copy_rd = 1'b1;
                o_ctrl.copy_wr = 1'b1;
                if (i_stat.copy_last) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_ctrl.fault_commit = 1'b1;
                n_state = S_READ;
            end
            S_READ: begin
                o_ctrl.phys_rd = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_ctrl.result = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_state != S_IDLE;
        end
    end

    assign o_busy = r_busy;
endmodule

[design/tlb_demand_paging_translator.sv]
// Top level of the TLB demand-paging address translator.
// One item at a time; busy is high while an item is in progress. A load
// writes its byte to the backing store; a translate scans the TLB and, on a
// miss, the page table entry by entry; a fault scans the whole table and adds
// the page copy through the memories. The result shows for one cycle with
// o_valid, in the cycle in which busy falls; the receiver cannot stall it.
module tlb_demand_paging_translator
    import tlbdp_pkg::*;
#(
    parameter int TLB_ENTRIES = 16,
    parameter int PAGE_COUNT  = 256,
    parameter int OFFSET_BITS = 8,
    parameter int STORE_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [15:0] i_address,
    input  logic signed [7:0] i_data_byte,
    output logic        o_valid,
    output logic [15:0] o_physical_address,
    output logic signed [7:0] o_value,
    output logic        o_tlb_hit,
    output logic        o_page_fault
);
    t_ctrl ctrl;
    t_stat stat;

    tlbdp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .o_busy(busy),
        .i_stat(stat), .o_ctrl(ctrl)
    );

    tlbdp_datapath #(
        .TLB_ENTRIES(TLB_ENTRIES), .PAGE_COUNT(PAGE_COUNT),
        .OFFSET_BITS(OFFSET_BITS), .STORE_BYTES(STORE_BYTES)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl), .o_stat(stat),
        .i_command(i_command), .i_address(i_address), .i_data_byte(i_data_byte),
        .o_valid(o_valid), .o_physical_address(o_physical_address),
        .o_value(o_value), .o_tlb_hit(o_tlb_hit), .o_page_fault(o_page_fault)
    );
endmodule
